// File: rtl/crcfr_pkg.sv
// shared types, constants and crc table for the crc fragment reassembler
package crcfr_pkg;

  localparam int HDR_BYTES = 16;
  localparam int CRC_BYTES = 4;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

  localparam logic [7:0] MAGIC_0 = 8'h41;
  localparam logic [7:0] MAGIC_1 = 8'h50;
  localparam logic [7:0] MAGIC_2 = 8'h58;
  localparam logic [7:0] MAGIC_3 = 8'h31;

  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_KEPT = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_BAD_HDR = 3'd2;
  localparam logic [2:0] ST_BAD_LEN = 3'd3;
  localparam logic [2:0] ST_BAD_CRC = 3'd4;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] ext;
    logic [7:0]  flags;
    logic [7:0]  stream;
  } hdr_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body;
    logic [2:0]  status;
    hdr_t        hdr;
    logic [31:0] len;
    logic        dropped;
  } res_t;

  function automatic logic [31:0] crc_table(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0: m = MAGIC_0;
      2'd1: m = MAGIC_1;
      2'd2: m = MAGIC_2;
      default: m = MAGIC_3;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/crc_fragment_reassembler.sv
// Frame deframer and fragment reassembler: takes one received byte per request, checks the
// magic and 16-byte header, runs the body through a reflected CRC-32 and passes each body
// byte on at once, then reports one status per frame; good fragments of equal sequence are
// chained into a message that a frame whose flags hit cfg_last_flag_mask completes. A byte
// is taken into an input register, processed once the queue has room, and its results
// written to a four-entry result queue that offers them on the output in order. The block
// takes one byte per cycle while in_stall is low; a frame's last byte can give two results
// (body byte and status), and the queue, draining one result per cycle while out_stall is
// low, raises in_stall for a held byte when it has room for fewer than two, counting a
// concurrent pop. No clearing pass follows reset. cfg_ready is always high.
module crc_fragment_reassembler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_body_byte,
  output logic [2:0]  out_status,
  output logic [7:0]  out_stream_id,
  output logic [7:0]  out_frame_flags,
  output logic [15:0] out_ext_words,
  output logic [31:0] out_sequence_res,
  output logic [31:0] out_message_len,
  output logic        out_dropped_partial,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_last_flag_mask
);
  import crcfr_pkg::*;

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       fire;
  logic       room;
  logic       pop;

  // frame and message state
  logic [31:0] pos_r, pos_nxt;
  logic [7:0]  hdr_r [HDR_BYTES];
  logic [7:0]  hdr_nxt [HDR_BYTES];
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;
  logic        bad_r, bad_nxt;
  logic        act_r, act_nxt;
  hdr_t        mhdr_r, mhdr_nxt;
  logic [31:0] mlen_r, mlen_nxt;
  logic [7:0]  mask_r;

  // lengths derived from the settled header
  logic [32:0] body_end_r, body_end_nxt;
  logic [32:0] frame_len_r, frame_len_nxt;
  logic [31:0] blen_r, blen_nxt;

  // result queue
  res_t             q_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    count_r;
  logic [1:0]       n_push;
  res_t             res0, res1;

  logic        body_emit;
  res_t        body_res, st_res;
  logic [31:0] got;
  logic [31:0] plen;
  logic        plen_short;
  hdr_t        fhdr;
  logic [1:0]  rc_idx;
  logic        seq_miss;
  logic        keep_msg;
  hdr_t        hdr_use;
  logic [31:0] base_len;
  logic [32:0] len_sum;
  logic [31:0] len_new;
  logic        complete;

  assign cfg_ready = 1'b1;

  assign pop = out_valid && !out_stall;
  assign room = (count_r <= (Q_AW+1)'(Q_DEPTH - 2)) ||
                (pop && count_r == (Q_AW+1)'(Q_DEPTH - 1));
  assign fire = in_v_r && room;
  assign in_stall = in_v_r && !room;

  assign plen = {hdr_r[11], hdr_r[10], hdr_r[9], hdr_r[8]};
  assign plen_short = plen < 32'(CRC_BYTES);

  always_comb begin
    body_end_nxt = {1'b0, plen} + 33'(HDR_BYTES - CRC_BYTES);
    frame_len_nxt = {1'b0, plen} + 33'(HDR_BYTES);
    blen_nxt = plen - 32'(CRC_BYTES);
  end

  always_comb begin
    pos_nxt = pos_r;
    hdr_nxt = hdr_r;
    crc_nxt = crc_r;
    rcrc_nxt = rcrc_r;
    bad_nxt = bad_r;
    act_nxt = act_r;
    mhdr_nxt = mhdr_r;
    mlen_nxt = mlen_r;
    body_emit = 1'b0;
    rc_idx = pos_r[1:0] - body_end_r[1:0];
    seq_miss = 1'b0;
    keep_msg = 1'b0;
    hdr_use = '0;
    base_len = '0;
    len_sum = '0;
    len_new = '0;
    complete = 1'b0;

    body_res = '0;
    body_res.kind = KIND_BODY;
    body_res.body = in_byte_r;

    if (pos_r < 32'(HDR_BYTES)) begin
      hdr_nxt[pos_r[3:0]] = in_byte_r;
      if (pos_r < 32'(CRC_BYTES) && in_byte_r != magic_byte(pos_r[1:0])) begin
        bad_nxt = 1'b1;
      end
    end else if (pos_r != ALL_ONES && !bad_r && !plen_short) begin
      if ({1'b0, pos_r} < body_end_r) begin
        crc_nxt = (crc_r >> 8) ^ crc_table(crc_r[7:0] ^ in_byte_r);
        body_emit = 1'b1;
      end else if ({1'b0, pos_r} < frame_len_r) begin
        rcrc_nxt[{rc_idx, 3'b000} +: 8] = in_byte_r;
      end
    end

    got = (pos_r == ALL_ONES) ? pos_r : pos_r + 32'd1;
    pos_nxt = got;

    fhdr.stream = hdr_nxt[4];
    fhdr.flags = hdr_nxt[5];
    fhdr.ext = {hdr_nxt[7], hdr_nxt[6]};
    fhdr.seq = {hdr_nxt[15], hdr_nxt[14], hdr_nxt[13], hdr_nxt[12]};

    st_res = '0;
    st_res.kind = KIND_STATUS;
    st_res.dropped = act_r;

    if (got < 32'(HDR_BYTES) || bad_nxt) begin
      st_res.status = ST_BAD_HDR;
    end else if (plen_short || {1'b0, got} < frame_len_r) begin
      st_res.status = ST_BAD_LEN;
      st_res.hdr = fhdr;
    end else if (~crc_nxt != rcrc_nxt) begin
      st_res.status = ST_BAD_CRC;
      st_res.hdr = fhdr;
    end else begin
      seq_miss = act_r && (mhdr_r.seq != fhdr.seq);
      keep_msg = act_r && !seq_miss;
      hdr_use = keep_msg ? mhdr_r : fhdr;
      base_len = keep_msg ? mlen_r : 32'd0;
      len_sum = {1'b0, base_len} + {1'b0, blen_r};
      len_new = len_sum[32] ? ALL_ONES : len_sum[31:0];
      complete = |(fhdr.flags & mask_r);
      st_res.status = complete ? ST_COMPLETE : ST_KEPT;
      st_res.hdr = hdr_use;
      st_res.len = len_new;
      st_res.dropped = seq_miss;
    end

    if (in_end_r) begin
      if (st_res.status == ST_KEPT) begin
        act_nxt = 1'b1;
        mhdr_nxt = hdr_use;
        mlen_nxt = len_new;
      end else begin
        act_nxt = 1'b0;
        mhdr_nxt = '0;
        mlen_nxt = '0;
      end
      pos_nxt = '0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_nxt[i] = '0;
      end
      crc_nxt = ALL_ONES;
      rcrc_nxt = '0;
      bad_nxt = 1'b0;
    end

    res0 = body_emit ? body_res : st_res;
    res1 = st_res;
    n_push = fire ? ({1'b0, body_emit} + {1'b0, in_end_r}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
      in_end_r <= in_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      mask_r <= cfg_last_flag_mask;
    end
  end

  always_ff @(posedge clk) begin
    body_end_r <= body_end_nxt;
    frame_len_r <= frame_len_nxt;
    blen_r <= blen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_r[i] <= '0;
      end
      crc_r <= ALL_ONES;
      rcrc_r <= '0;
      bad_r <= 1'b0;
      act_r <= 1'b0;
      mhdr_r <= '0;
      mlen_r <= '0;
    end else if (fire) begin
      pos_r <= pos_nxt;
      hdr_r <= hdr_nxt;
      crc_r <= crc_nxt;
      rcrc_r <= rcrc_nxt;
      bad_r <= bad_nxt;
      act_r <= act_nxt;
      mhdr_r <= mhdr_nxt;
      mlen_r <= mlen_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + Q_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_AW'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      count_r <= count_r + (Q_AW+1)'(n_push) - (Q_AW+1)'(pop);
    end
  end

  assign out_valid = count_r != '0;
  assign out_kind = q_r[rd_ptr_r].kind;
  assign out_body_byte = q_r[rd_ptr_r].body;
  assign out_status = q_r[rd_ptr_r].status;
  assign out_stream_id = q_r[rd_ptr_r].hdr.stream;
  assign out_frame_flags = q_r[rd_ptr_r].hdr.flags;
  assign out_ext_words = q_r[rd_ptr_r].hdr.ext;
  assign out_sequence_res = q_r[rd_ptr_r].hdr.seq;
  assign out_message_len = q_r[rd_ptr_r].len;
  assign out_dropped_partial = q_r[rd_ptr_r].dropped;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("result queue overfilled");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r && count_r >= (Q_AW+1)'(Q_DEPTH - 2))
    else $error("input stalled without a held request or a full queue");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_end_r |=> pos_r == '0 && crc_r == ALL_ONES && !bad_r)
    else $error("frame state not cleared after frame end");

  a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BODY |->
      out_status == ST_KEPT && !out_dropped_partial && out_message_len == '0)
    else $error("body result carries status fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_status <= ST_BAD_CRC)
    else $error("status code out of range");

  a_complete_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_end_r && st_res.status != ST_KEPT |=> !act_r && mlen_r == '0)
    else $error("message kept after completion or error");
`endif

endmodule
